// File: rtl/core/archive_stream_parse_verify_macros.svh
// assertion macros used by the port-level checker
`ifndef ARCHIVE_STREAM_PARSE_VERIFY_MACROS_SVH
`define ARCHIVE_STREAM_PARSE_VERIFY_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASV_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define ASV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/core/asv_pkg.sv
// package: field widths, phase codes, result kinds, status codes and crc helper
package asv_pkg;
  localparam int unsigned PathBytesDefault = 256;
  localparam logic [31:0] CrcSeedReset = 32'h5A3C9E71;
  localparam logic [7:0] MaskReset = 8'hA5;
  localparam logic [7:0] VersionReset = 8'h02;
  localparam logic [31:0] CrcPoly = 32'hEDB88320;

  localparam logic [1:0] RegCrcSeed = 2'd0;
  localparam logic [1:0] RegMask = 2'd1;
  localparam logic [1:0] RegVersion = 2'd2;

  localparam logic [2:0] KindHeader = 3'd0;
  localparam logic [2:0] KindPath = 3'd1;
  localparam logic [2:0] KindMeta = 3'd2;
  localparam logic [2:0] KindData = 3'd3;
  localparam logic [2:0] KindSum = 3'd4;
  localparam logic [2:0] KindFooter = 3'd5;
  localparam logic [2:0] KindIgnored = 3'd6;

  localparam logic [2:0] StParsing = 3'd0;
  localparam logic [2:0] StComplete = 3'd1;
  localparam logic [2:0] StBadMagic = 3'd2;
  localparam logic [2:0] StBadVersion = 3'd3;
  localparam logic [2:0] StPathLong = 3'd4;
  localparam logic [2:0] StBadFooter = 3'd5;

  typedef enum logic [3:0] {
    PH_MAGIC, PH_VERSION, PH_FLAGS, PH_COUNT, PH_PLEN, PH_PATH, PH_TYPE,
    PH_MODE, PH_MTIME, PH_SIZE, PH_DATA, PH_SUM, PH_FOOTER, PH_END
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic start_archive;
  } in_item_t;

  typedef struct packed {
    logic [2:0] byte_kind;
    logic [7:0] plain_byte;
    logic entry_done;
    logic [31:0] entry_number;
    logic is_directory;
    logic [15:0] entry_mode;
    logic signed [63:0] entry_mtime;
    logic [31:0] entry_size;
    logic sum_present;
    logic sum_matches;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    logic [31:0] crc_seed;
    logic [7:0] scramble_mask;
    logic [7:0] expected_version;
  } cfg_t;

  function automatic logic [7:0] head_mark(input logic [1:0] i);
    logic [7:0] r;
    unique case (i)
      2'd0: r = 8'h41;
      2'd1: r = 8'h52;
      2'd2: r = 8'h4B;
      default: r = 8'h56;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] tail_mark(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0: r = 8'h41;
      3'd1: r = 8'h52;
      3'd2: r = 8'h4B;
      3'd3: r = 8'h56;
      3'd4: r = 8'h5F;
      3'd5: r = 8'h45;
      3'd6: r = 8'h4E;
      default: r = 8'h44;
    endcase
    return r;
  endfunction

  // one byte of reflected crc-32, eight narrow dependent steps
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CrcPoly) : (x >> 1);
    end
    return x;
  endfunction
endpackage

// File: rtl/core/asv_stream_if.sv
// valid/ready channel carrying one payload
interface asv_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/asv_cfg_regs.sv
// configuration register file
module asv_cfg_regs (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [1:0] cfg_index,
  input logic [31:0] cfg_data,
  output asv_pkg::cfg_t cfg
);
  import asv_pkg::*;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crc_seed <= CrcSeedReset;
      cfg.scramble_mask <= MaskReset;
      cfg.expected_version <= VersionReset;
    end else if (cfg_we) begin
      if (cfg_index == RegCrcSeed) cfg.crc_seed <= cfg_data;
      if (cfg_index == RegMask) cfg.scramble_mask <= cfg_data[7:0];
      if (cfg_index == RegVersion) cfg.expected_version <= cfg_data[7:0];
    end
  end
endmodule

// File: rtl/core/asv_parser.sv
// parser datapath: one byte per cycle while step is high, path buffer memory, crc and result register
module asv_parser #(
  parameter int unsigned PATH_BYTES = asv_pkg::PathBytesDefault
) (
  input logic clk,
  input logic rst,
  input asv_pkg::cfg_t cfg,
  input logic step,
  input asv_pkg::in_item_t item,
  output asv_pkg::out_item_t result
);
  import asv_pkg::*;

  localparam int unsigned AW = (PATH_BYTES > 1) ? $clog2(PATH_BYTES) : 1;

  phase_t phase, phase_next;
  logic [2:0] fbi, fbi_next;
  logic [63:0] fshift, fshift_next;
  logic [1:0] flags, flags_next;
  logic [31:0] entries_left, entries_left_next;
  logic [31:0] counter, counter_next;
  logic [15:0] path_length, path_length_next;
  logic [15:0] key_pos, key_pos_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [31:0] crc, crc_next;
  logic [15:0] l_mode, l_mode_next;
  logic [63:0] l_mtime, l_mtime_next;
  logic [31:0] l_size, l_size_next;
  logic l_dir, l_dir_next;
  logic [2:0] stat, stat_next;
  logic [7:0] path_mem [PATH_BYTES];
  logic [7:0] key_byte;
  logic [7:0] next_key_byte;
  logic [AW-1:0] rd_addr;
  logic mem_we;
  out_item_t res;

  // restart view of the state
  phase_t ph;
  logic [2:0] fb;
  logic [1:0] fl;
  logic [31:0] el, cnt, crc0;
  logic [15:0] plen, kp;
  logic [15:0] mo;
  logic [63:0] mt;
  logic [31:0] sz;
  logic dr;
  logic [2:0] st;
  logic [63:0] acc;
  logic [7:0] b, p;
  logic last;

  always_comb begin
    b = item.in_byte;
    if (item.start_archive) begin
      ph = PH_MAGIC; fb = '0; fl = '0; el = '0; cnt = '0; plen = '0; kp = '0;
      crc0 = ~cfg.crc_seed; mo = '0; mt = '0; sz = '0; dr = 1'b0; st = StParsing;
    end else begin
      ph = phase; fb = fbi; fl = flags; el = entries_left; cnt = counter;
      plen = path_length; kp = key_pos; crc0 = crc; mo = l_mode; mt = l_mtime;
      sz = l_size; dr = l_dir; st = stat;
    end
    phase_next = ph; fbi_next = fb; flags_next = fl; entries_left_next = el;
    counter_next = cnt; path_length_next = plen; key_pos_next = kp;
    bytes_left_next = bytes_left; crc_next = crc0; l_mode_next = mo;
    l_mtime_next = mt; l_size_next = sz; l_dir_next = dr; stat_next = st;
    fshift_next = fshift;
    mem_we = 1'b0;
    p = b;
    res = '0;
    res.byte_kind = KindIgnored;
    // little-endian field collection
    acc = (fb == 3'd0) ? 64'd0 : fshift;
    acc = acc | ({56'd0, b} << {fb, 3'b000});
    last = 1'b0;

    unique case (ph)
      PH_MAGIC: begin
        res.byte_kind = KindHeader;
        if (b != head_mark(fb[1:0])) begin
          stat_next = StBadMagic; phase_next = PH_END;
        end else if (fb == 3'd3) begin
          fbi_next = '0; phase_next = PH_VERSION;
        end else fbi_next = fb + 3'd1;
      end
      PH_VERSION: begin
        res.byte_kind = KindHeader;
        if (b != cfg.expected_version) begin
          stat_next = StBadVersion; phase_next = PH_END;
        end else phase_next = PH_FLAGS;
      end
      PH_FLAGS: begin
        res.byte_kind = KindHeader;
        flags_next = b[1:0]; fbi_next = '0; phase_next = PH_COUNT;
      end
      PH_COUNT: begin
        res.byte_kind = KindHeader;
        fshift_next = acc;
        if (fb == 3'd3) begin
          fbi_next = '0; entries_left_next = acc[31:0];
          phase_next = (acc[31:0] == 32'd0) ? PH_FOOTER : PH_PLEN;
        end else fbi_next = fb + 3'd1;
      end
      PH_PLEN: begin
        res.byte_kind = KindMeta;
        fshift_next = acc;
        if (fb == 3'd0) begin
          l_dir_next = 1'b0; l_mode_next = '0; l_mtime_next = '0; l_size_next = '0;
          fbi_next = 3'd1;
        end else begin
          fbi_next = '0; path_length_next = acc[15:0]; key_pos_next = '0;
          if (32'(acc[15:0]) > 32'(PATH_BYTES)) begin
            stat_next = StPathLong; phase_next = PH_END;
          end else phase_next = (acc[15:0] == 16'd0) ? PH_TYPE : PH_PATH;
        end
      end
      PH_PATH: begin
        res.byte_kind = KindPath;
        mem_we = 32'(kp) < 32'(PATH_BYTES);
        key_pos_next = kp + 16'd1;
        if (kp + 16'd1 >= plen) phase_next = PH_TYPE;
      end
      PH_TYPE: begin
        res.byte_kind = KindMeta;
        l_dir_next = (b == 8'h01); fbi_next = '0; phase_next = PH_MODE;
      end
      PH_MODE: begin
        res.byte_kind = KindMeta;
        fshift_next = acc;
        if (fb == 3'd1) begin
          fbi_next = '0; l_mode_next = acc[15:0]; phase_next = PH_MTIME;
        end else fbi_next = fb + 3'd1;
      end
      PH_MTIME: begin
        res.byte_kind = KindMeta;
        fshift_next = acc;
        if (fb == 3'd7) begin
          fbi_next = '0; l_mtime_next = acc; phase_next = PH_SIZE;
        end else fbi_next = fb + 3'd1;
      end
      PH_SIZE: begin
        res.byte_kind = KindMeta;
        fshift_next = acc;
        if (fb == 3'd3) begin
          fbi_next = '0; l_size_next = acc[31:0]; bytes_left_next = acc[31:0];
          crc_next = ~cfg.crc_seed; key_pos_next = '0;
          if (acc[31:0] == 32'd0) begin
            if (fl[0]) phase_next = PH_SUM;
            else begin
              res.entry_done = 1'b1; last = 1'b1;
            end
          end else phase_next = PH_DATA;
        end else fbi_next = fb + 3'd1;
      end
      PH_DATA: begin
        res.byte_kind = KindData;
        if (fl[1] && plen != 16'd0 && kp < plen && 32'(kp) < 32'(PATH_BYTES))
          p = b ^ key_byte ^ cfg.scramble_mask;
        key_pos_next = (kp + 16'd1 >= plen) ? 16'd0 : kp + 16'd1;
        crc_next = crc_byte(crc0, p);
        bytes_left_next = bytes_left - 32'd1;
        if (bytes_left == 32'd1) begin
          if (fl[0]) begin
            phase_next = PH_SUM; fbi_next = '0;
          end else begin
            res.entry_done = 1'b1; last = 1'b1;
          end
        end
      end
      PH_SUM: begin
        res.byte_kind = KindSum;
        fshift_next = acc;
        if (fb == 3'd3) begin
          res.sum_matches = acc[31:0] == ((sz == 32'd0) ? 32'd0 : ~crc0);
          res.entry_done = 1'b1; last = 1'b1;
        end else fbi_next = fb + 3'd1;
      end
      PH_FOOTER: begin
        res.byte_kind = KindFooter;
        if (b != tail_mark(fb)) begin
          stat_next = StBadFooter; phase_next = PH_END;
        end else if (fb == 3'd7) begin
          fbi_next = '0; stat_next = StComplete; phase_next = PH_END;
        end else fbi_next = fb + 3'd1;
      end
      default: res.byte_kind = KindIgnored;
    endcase

    // entry completion
    if (last) begin
      counter_next = cnt + 32'd1;
      entries_left_next = el - 32'd1;
      fbi_next = '0;
      phase_next = (el == 32'd1) ? PH_FOOTER : PH_PLEN;
    end

    res.plain_byte = p;
    res.entry_number = cnt;
    res.is_directory = l_dir_next;
    res.entry_mode = l_mode_next;
    res.entry_mtime = l_mtime_next;
    res.entry_size = l_size_next;
    res.sum_present = flags_next[0];
    res.status = stat_next;
  end

  // key byte for the next data byte, read ahead from the path buffer
  always_comb begin
    rd_addr = key_pos_next[AW-1:0];
    if (32'(key_pos_next) >= 32'(PATH_BYTES)) rd_addr = '0;
  end

  // path buffer write, registered read with bypass of this cycle's write
  always_ff @(posedge clk) begin
    if (step && mem_we) path_mem[kp[AW-1:0]] <= b;
    if (step) next_key_byte <= path_mem[rd_addr];
  end

  logic byp_valid;
  logic [7:0] byp_data;
  always_ff @(posedge clk) begin
    if (step) begin
      byp_valid <= mem_we && (kp[AW-1:0] == rd_addr);
      byp_data <= b;
    end
  end
  assign key_byte = byp_valid ? byp_data : next_key_byte;

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_MAGIC; fbi <= '0; fshift <= '0; flags <= '0; entries_left <= '0;
      counter <= '0; path_length <= '0; key_pos <= '0; bytes_left <= '0;
      crc <= ~CrcSeedReset; l_mode <= '0; l_mtime <= '0; l_size <= '0;
      l_dir <= 1'b0; stat <= StParsing;
    end else if (step) begin
      phase <= phase_next; fbi <= fbi_next; fshift <= fshift_next;
      flags <= flags_next; entries_left <= entries_left_next;
      counter <= counter_next; path_length <= path_length_next;
      key_pos <= key_pos_next; bytes_left <= bytes_left_next; crc <= crc_next;
      l_mode <= l_mode_next; l_mtime <= l_mtime_next; l_size <= l_size_next;
      l_dir <= l_dir_next; stat <= stat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) result <= res;
  end
endmodule

// File: rtl/core/archive_stream_parse_verify.sv
// top level of the archive stream parser and verifier
// Usage:
//   in_ch carries one archive byte per request with start_archive marking the
//   first magic byte of a new archive. out_ch returns one result per request:
//   the byte kind, the plain (descrambled) byte, entry metadata, crc match and
//   status. Configuration (crc seed, scramble mask, expected version) is
//   written through cfg_we / cfg_index / cfg_data while the block is idle.
//   The result of a request appears on out_ch in the cycle after the
//   request is taken. Throughput: one request per cycle while out_ch is ready,
//   set by the single result register and the byte-wide crc in front of it;
//   the path buffer read is registered and done ahead for the next data byte.
//   When the receiver stalls, the held result stays on out_ch and in_ch is
//   ready only when the result register is empty or being drained.
//   Reset (rst, synchronous) returns the parser to the magic phase, clears the
//   output valid and restores the register defaults; the path buffer is not
//   cleared since every entry is written before it is read.
module archive_stream_parse_verify #(
  parameter int unsigned PATH_BYTES = asv_pkg::PathBytesDefault
) (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [1:0] cfg_index,
  input logic [31:0] cfg_data,
  asv_stream_if.sink in_ch,
  asv_stream_if.source out_ch
);
  import asv_pkg::*;

  cfg_t cfg;
  out_item_t result;
  logic step;
  logic out_valid;

  asv_cfg_regs u_cfg (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  // accept when the output register is free or draining
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign step = in_ch.valid && in_ch.ready;

  asv_parser #(.PATH_BYTES(PATH_BYTES)) u_parser (
    .clk(clk), .rst(rst), .cfg(cfg), .step(step), .item(in_ch.data),
    .result(result)
  );

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (step) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data = result;
endmodule

// File: rtl/core/asv_checker.sv
// port-level checker for the archive parser, bound to the top level
`include "archive_stream_parse_verify_macros.svh"
module asv_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input asv_pkg::out_item_t out_data
);
  import asv_pkg::*;

  // a taken request always yields a result next cycle
  `ASV_ASSERT_NEXT(a_result_follows, clk, rst, in_valid && in_ready, out_valid)
  // stalled result holds
  `ASV_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, $stable(out_data))
  // never stall input while output is empty
  `ASV_ASSERT_IMP(a_ready_empty, clk, rst, !out_valid, in_ready)
  // entry completion only on meta, data or checksum bytes
  `ASV_ASSERT_IMP(a_done_kind, clk, rst, out_valid && out_data.entry_done,
    out_data.byte_kind == KindMeta || out_data.byte_kind == KindData ||
    out_data.byte_kind == KindSum)
  // match only reported with checksums present
  `ASV_ASSERT_IMP(a_match_sum, clk, rst, out_valid && out_data.sum_matches,
    out_data.sum_present && out_data.entry_done)
endmodule

bind archive_stream_parse_verify asv_checker u_asv_checker (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// File: dv/archive_stream_parse_verify_checker.sv
// checker: watches the archive byte channels, predicts every result and compares
module archive_stream_parse_verify_checker
  import asv_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [1:0] cfg_index,
  input logic [31:0] cfg_data,
  asv_stream_if in_ch,
  asv_stream_if out_ch,
  output int fail_count,
  output int pending,
  output int checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PathBytes = PathBytesDefault;
  localparam logic [7:0] HeadBytes [4] = '{8'h41, 8'h52, 8'h4B, 8'h56};
  localparam logic [7:0] TailBytes [8] =
    '{8'h41, 8'h52, 8'h4B, 8'h56, 8'h5F, 8'h45, 8'h4E, 8'h44};

  // mirrored registers
  logic [31:0] seed;
  logic [7:0] mask;
  logic [7:0] version;

  // parser state
  phase_t ph;
  int unsigned fbi;
  logic [63:0] fsh;
  logic [1:0] flg;
  logic [31:0] eleft, ecnt;
  logic [15:0] plen, kpos;
  logic [7:0] pstore [PathBytes];
  logic [31:0] bleft, crc, ssum;
  logic [15:0] lmode;
  logic [63:0] lmtime;
  logic [31:0] lsize;
  logic ldir;
  logic [2:0] st;

  out_item_t expected_results [$];

  function automatic void restart_parser();
    ph = PH_MAGIC;
    fbi = 0;
    fsh = '0;
    flg = '0;
    eleft = '0;
    ecnt = '0;
    plen = '0;
    kpos = '0;
    bleft = '0;
    crc = ~seed;
    ssum = '0;
    lmode = '0;
    lmtime = '0;
    lsize = '0;
    ldir = 1'b0;
    st = StParsing;
  endfunction

  // little-endian field assembly, true once n bytes are in
  function automatic bit gather(input logic [7:0] b, input int unsigned n);
    if (fbi == 0) fsh = '0;
    fsh |= 64'(b) << (8 * (fbi & 7));
    fbi++;
    if (fbi >= n) begin
      fbi = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ 32'(b);
    for (int k = 0; k < 8; k++) x = x[0] ? ((x >> 1) ^ 32'hEDB88320) : (x >> 1);
    return x;
  endfunction

  function automatic void close_entry();
    ecnt++;
    eleft--;
    fbi = 0;
    ph = (eleft == 0) ? PH_FOOTER : PH_PLEN;
  endfunction

  // returns 1 when the entry ends here (no checksum field follows)
  function automatic bit end_data();
    if (flg[0]) begin
      ph = PH_SUM;
      fbi = 0;
      return 1'b0;
    end
    close_entry();
    return 1'b1;
  endfunction

  function automatic out_item_t parse_byte(input in_item_t it);
    out_item_t r;
    logic [7:0] b, p;
    logic [2:0] kind;
    bit done, match;
    logic [31:0] idx;
    b = it.in_byte;
    p = b;
    kind = KindIgnored;
    done = 0;
    match = 0;
    if (it.start_archive) restart_parser();
    idx = ecnt;
    case (ph)
      PH_MAGIC: begin
        kind = KindHeader;
        if (b != HeadBytes[fbi & 3]) begin
          st = StBadMagic;
          ph = PH_END;
        end else begin
          fbi++;
          if (fbi >= 4) begin
            fbi = 0;
            ph = PH_VERSION;
          end
        end
      end
      PH_VERSION: begin
        kind = KindHeader;
        if (b != version) begin
          st = StBadVersion;
          ph = PH_END;
        end else ph = PH_FLAGS;
      end
      PH_FLAGS: begin
        kind = KindHeader;
        flg = b[1:0];
        fbi = 0;
        ph = PH_COUNT;
      end
      PH_COUNT: begin
        kind = KindHeader;
        if (gather(b, 4)) begin
          eleft = fsh[31:0];
          ph = (eleft == 0) ? PH_FOOTER : PH_PLEN;
        end
      end
      PH_PLEN: begin
        kind = KindMeta;
        if (fbi == 0) begin
          ldir = 1'b0;
          lmode = '0;
          lmtime = '0;
          lsize = '0;
        end
        if (gather(b, 2)) begin
          plen = fsh[15:0];
          kpos = '0;
          if (32'(plen) > PathBytes) begin
            st = StPathLong;
            ph = PH_END;
          end else ph = (plen == 0) ? PH_TYPE : PH_PATH;
        end
      end
      PH_PATH: begin
        kind = KindPath;
        if (32'(kpos) < PathBytes) pstore[kpos] = b;
        kpos++;
        if (kpos >= plen) ph = PH_TYPE;
      end
      PH_TYPE: begin
        kind = KindMeta;
        ldir = (b == 8'd1);
        fbi = 0;
        ph = PH_MODE;
      end
      PH_MODE: begin
        kind = KindMeta;
        if (gather(b, 2)) begin
          lmode = fsh[15:0];
          ph = PH_MTIME;
        end
      end
      PH_MTIME: begin
        kind = KindMeta;
        if (gather(b, 8)) begin
          lmtime = fsh;
          ph = PH_SIZE;
        end
      end
      PH_SIZE: begin
        kind = KindMeta;
        if (gather(b, 4)) begin
          lsize = fsh[31:0];
          bleft = lsize;
          crc = ~seed;
          kpos = '0;
          if (bleft == 0) done = end_data();
          else ph = PH_DATA;
        end
      end
      PH_DATA: begin
        kind = KindData;
        if (flg[1] && plen != 0 && kpos < plen && 32'(kpos) < PathBytes)
          p = b ^ pstore[kpos] ^ mask;
        kpos++;
        if (kpos >= plen) kpos = '0;
        crc = crc_step(crc, p);
        bleft--;
        if (bleft == 0) done = end_data();
      end
      PH_SUM: begin
        kind = KindSum;
        if (gather(b, 4)) begin
          ssum = fsh[31:0];
          // an empty entry sums to zero, not to the seed
          match = (ssum == ((lsize == 0) ? 32'd0 : ~crc));
          done = 1;
          close_entry();
        end
      end
      PH_FOOTER: begin
        kind = KindFooter;
        if (b != TailBytes[fbi & 7]) begin
          st = StBadFooter;
          ph = PH_END;
        end else begin
          fbi++;
          if (fbi >= 8) begin
            fbi = 0;
            st = StComplete;
            ph = PH_END;
          end
        end
      end
      default: kind = KindIgnored;
    endcase
    r.byte_kind = kind;
    r.plain_byte = p;
    r.entry_done = done;
    r.entry_number = idx;
    r.is_directory = ldir;
    r.entry_mode = lmode;
    r.entry_mtime = lmtime;
    r.entry_size = lsize;
    r.sum_present = flg[0];
    r.sum_matches = match;
    r.status = st;
    return r;
  endfunction

  assign pending = expected_results.size();

  // predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    out_item_t exp_r, got;
    if (rst) begin
      seed = CrcSeedReset;
      mask = MaskReset;
      version = VersionReset;
      restart_parser();
      expected_results.delete();
      fail_count <= 0;
      checked_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegCrcSeed: seed = cfg_data;
          RegMask: mask = cfg_data[7:0];
          RegVersion: version = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) expected_results.push_back(parse_byte(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        checked_count <= checked_count + 1;
        if (expected_results.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %p", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("mismatch\n  exp %p\n  got %p", exp_r, got);
          end
        end
      end
    end
  end
endmodule

// File: dv/archive_stream_parse_verify_tb.sv
// testbench top: archive byte stimulus, register settings, stall phases and verdict
module archive_stream_parse_verify_tb;
  import asv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 20000;
  localparam int FlawNone = 0;
  localparam int FlawMagic = 1;
  localparam int FlawVersion = 2;
  localparam int FlawFooter = 3;
  localparam int FlawLongPath = 4;
  localparam int FlawCut = 5;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int fail_count, pending, checked_count;
  int idle_pct = 0, stall_pct = 0;
  int wd = 0;
  int archives = 0, entries = 0;
  logic [31:0] cur_seed = CrcSeedReset;
  logic [7:0] cur_mask = MaskReset;
  logic [7:0] cur_ver = VersionReset;
  in_item_t stim [$];
  bit first;

  asv_stream_if #(.payload_t(in_item_t)) in_ch (clk);
  asv_stream_if #(.payload_t(out_item_t)) out_ch (clk);

  archive_stream_parse_verify u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  archive_stream_parse_verify_checker u_chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch), .fail_count(fail_count), .pending(pending),
    .checked_count(checked_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver stalls
  initial out_ch.ready = 1'b0;
  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  // no progress on either channel for too long ends the run
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) wd <= 0;
    else wd <= wd + 1;
    if (wd >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void put(input logic [7:0] b);
    in_item_t it;
    it.in_byte = b;
    it.start_archive = first;
    stim.push_back(it);
    first = 1'b0;
  endfunction

  function automatic void put_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) put(v[8*i +: 8]);
  endfunction

  function automatic logic [31:0] sum_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) x = x[0] ? ((x >> 1) ^ 32'hEDB88320) : (x >> 1);
    return x;
  endfunction

  // one archive, well formed unless a flaw is asked for, then up to two bytes of trailing noise
  function automatic void make_archive(input bit stray, input int nent, input int flaw);
    int s0, r, plen, sz;
    logic [7:0] flags, raw, plain;
    logic [7:0] pth [$];
    logic [31:0] c, sum;
    s0 = stim.size();
    first = !stray;
    archives++;
    put(8'h41); put(8'h52); put(8'h4B); put(8'h56);
    put(cur_ver);
    flags = 8'($urandom);
    put(flags);
    put_le((flaw == FlawCut) ? 64'($urandom) : 64'(nent), 4);
    for (int e = 0; e < nent; e++) begin
      r = $urandom_range(99);
      if (flaw == FlawLongPath && e == nent - 1) begin
        plen = (r < 30) ? 257 : (r < 50) ? 65535 : $urandom_range(258, 65534);
        put_le(64'(plen), 2);
        break;
      end
      plen = (r < 3) ? 256 : (r < 15) ? 0 : $urandom_range(1, 6);
      put_le(64'(plen), 2);
      pth.delete();
      for (int i = 0; i < plen; i++) begin
        pth.push_back(8'($urandom));
        put(pth[i]);
      end
      put(($urandom_range(99) < 40) ? 8'd1 : 8'($urandom));
      put_le(64'($urandom), 2);
      put_le({$urandom, $urandom}, 8);
      r = $urandom_range(99);
      sz = (r < 15) ? 0 : (r < 20) ? 40 : $urandom_range(1, 10);
      put_le(64'(sz), 4);
      c = ~cur_seed;
      for (int i = 0; i < sz; i++) begin
        raw = 8'($urandom);
        plain = (flags[1] && plen != 0) ? raw ^ pth[i % plen] ^ cur_mask : raw;
        c = sum_step(c, plain);
        put(raw);
      end
      sum = (sz == 0) ? 32'd0 : ~c;
      if (flags[0]) put_le(($urandom_range(99) < 80) ? 64'(sum) : 64'($urandom), 4);
      entries++;
    end
    if (flaw != FlawLongPath) begin
      put(8'h41); put(8'h52); put(8'h4B); put(8'h56);
      put(8'h5F); put(8'h45); put(8'h4E); put(8'h44);
    end
    case (flaw)
      FlawMagic: stim[s0 + $urandom_range(3)].in_byte ^= 8'($urandom_range(1, 255));
      FlawVersion: stim[s0 + 4].in_byte ^= 8'($urandom_range(1, 255));
      FlawFooter: stim[stim.size() - 1 - $urandom_range(7)].in_byte ^=
                  8'($urandom_range(1, 255));
      FlawCut: begin
        r = $urandom_range(5, stim.size() - s0 - 1);
        while (stim.size() > s0 + r) void'(stim.pop_back());
      end
      default: ;
    endcase
    r = $urandom_range(2);
    for (int i = 0; i < r; i++) put(8'($urandom));
  endfunction

  task automatic send(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_all();
    while (stim.size() != 0) send(stim.pop_front());
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] s, input logic [7:0] m, input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_index <= RegCrcSeed;
    cfg_data <= s;
    @(posedge clk);
    cfg_index <= RegMask;
    cfg_data <= {24'd0, m};
    @(posedge clk);
    cfg_index <= RegVersion;
    cfg_data <= {24'd0, v};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_seed = s;
    cur_mask = m;
    cur_ver = v;
  endtask

  initial begin
    int sent, r, flaw;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: unmarked (stray) empty archive parsed as magic, then a magic, a version and a long-path flaw
    make_archive(1'b1, 0, FlawNone);
    make_archive(1'b0, 1, FlawMagic);
    make_archive(1'b0, 1, FlawVersion);
    make_archive(1'b0, 1, FlawLongPath);
    send_all();
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        1: begin
          write_regs(32'd0, 8'd0, 8'd0);
          idle_pct = 68;
          stall_pct = 0;
        end
        2: begin
          write_regs(32'hFFFF_FFFF, 8'hFF, 8'hFF);
          idle_pct = 0;
          stall_pct = 68;
        end
        3: begin
          write_regs($urandom, 8'($urandom), 8'($urandom));
          idle_pct = 11;
          stall_pct = 11;
        end
        default: ;
      endcase
      sent = 0;
      while (sent < 400) begin
        r = $urandom_range(99);
        flaw = (r < 80) ? FlawNone : (r < 84) ? FlawMagic : (r < 88) ? FlawVersion :
               (r < 92) ? FlawFooter : (r < 95) ? FlawLongPath : FlawCut;
        make_archive(1'b0, ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3), flaw);
        sent += stim.size();
        send_all();
        // sometimes hold the sender until every result is back
        if ($urandom_range(7) == 0) drain();
      end
      drain();
    end

    $display("covered %0d archives with %0d entries, %0d results checked over 4 settings",
             archives, entries, checked_count);
    if (fail_count == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
